### rtl/ptw_pkg.sv
// shared constants and types for the four-level page table walker
// no dependencies; imported by ptw_addr_unit and the top level
`default_nettype none

package ptw_pkg;

  // physical memory geometry
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  // table geometry
  localparam int LEVELS     = 4;
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int IDX_BITS   = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int SH_W       = 7;
  localparam int WADDR_W    = 61;

  localparam logic [63:0] PAGE_MASK = 64'h0000_0000_0000_0fff;

  // request kinds
  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // entry read request from the shared address unit
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } rd_req_t;

endpackage

`default_nettype wire

### rtl/ptw_addr_unit.sv
// shared entry address unit: index extract, base add and range compare
// depends on ptw_pkg
`default_nettype none

module ptw_addr_unit
  import ptw_pkg::*;
(
  input  wire logic [63:0]      base,
  input  wire logic [63:0]      lin,
  input  wire logic [LVL_W-1:0] level,
  output rd_req_t               req
);

  logic [LVL_W-1:0]    lvl_m1;
  logic [SH_W-1:0]     sh;
  logic [63:0]         shifted;
  logic [IDX_BITS-1:0] idx;
  logic [WADDR_W-1:0]  word;

  // nine index bits of the linear address for this level
  always_comb begin
    lvl_m1  = level - LVL_W'(1);
    sh      = SH_W'(PAGE_SHIFT) + SH_W'(IDX_BITS) * SH_W'(lvl_m1);
    shifted = lin >> sh;
    idx     = shifted[IDX_BITS-1:0];
  end

  // word address of the entry, base low bits are already clear
  always_comb begin
    word     = base[63:3] + WADDR_W'(idx);
    req.addr = word[ADDR_W-1:0];
    req.hit  = (word < WADDR_W'(MEM_WORDS));
  end

endmodule

`default_nettype wire

### rtl/four_level_page_table_walker_core.sv
// Four-level page table walker over a 4096-word physical memory. After reset the block
// sweeps the memory to zero, one word a cycle, and takes no input word meanwhile (root
// writes are taken at any time). A translate word steps through accept, address issue,
// one dependent entry read per table level through the single memory read port, and the
// result hand-off; a walk that meets a clear present bit ends at that level. The result
// sits in an output register, so write words are accepted while a result waits to be taken.
// depends on ptw_pkg and ptw_addr_unit
`default_nettype none

module four_level_page_table_walker_core
  import ptw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // root register write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] page_table_root,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [11:0] word_index,
  input  wire logic [63:0] write_data,
  input  wire logic [63:0] linear_addr,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             mapped,
  output logic [63:0]      physical_addr
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [63:0]       root;
  logic [63:0]       table_base;
  logic [63:0]       held_linear_addr;
  logic [LVL_W-1:0]  walk_level;
  logic              rd_hit;
  logic [63:0]       rd_data;
  logic              res_mapped;
  logic [63:0]       res_addr;

  logic [63:0]       mem [MEM_WORDS];

  logic              in_take;
  logic              out_free;
  logic [63:0]       entry;
  logic [63:0]       entry_base;
  logic [63:0]       unit_base;
  logic [LVL_W-1:0]  unit_level;
  rd_req_t           rd_req;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [63:0]       mem_wd;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root <= page_table_root;
    end
  end

  // entry seen this cycle, zero when it lies beyond memory
  always_comb begin
    entry      = rd_hit ? rd_data : '0;
    entry_base = entry & ~PAGE_MASK;
  end

  // shared address unit input select
  always_comb begin
    if (state == S_WALK) begin
      unit_base  = entry_base;
      unit_level = walk_level - LVL_W'(1);
    end else begin
      unit_base  = table_base;
      unit_level = walk_level;
    end
  end

  ptw_addr_unit u_addr (
    .base  (unit_base),
    .lin   (held_linear_addr),
    .level (unit_level),
    .req   (rd_req)
  );

  // memory write port: clearing sweep or write word
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wd = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_take && req_type == REQ_WRITE &&
                 32'(word_index) < 32'(MEM_WORDS)) begin
      mem_we = 1'b1;
      mem_wa = ADDR_W'(word_index);
      mem_wd = write_data;
    end
  end

  // physical memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_req.addr];
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      walk_level <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take && req_type == REQ_TRANSLATE) begin
            walk_level <= LVL_W'(LEVELS);
            state      <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (!entry[0] || walk_level == LVL_W'(1)) begin
            state <= S_DONE;
          end else begin
            walk_level <= walk_level - LVL_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_take && req_type == REQ_TRANSLATE) begin
      held_linear_addr <= linear_addr;
      table_base       <= root & ~PAGE_MASK;
    end
    if (state == S_ISSUE || state == S_WALK) begin
      rd_hit <= rd_req.hit;
    end
    if (state == S_WALK) begin
      if (!entry[0]) begin
        res_mapped <= 1'b0;
        res_addr   <= '0;
      end else begin
        res_mapped <= 1'b1;
        res_addr   <= entry_base | (held_linear_addr & PAGE_MASK);
        table_base <= entry_base;
      end
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      mapped        <= res_mapped;
      physical_addr <= res_addr;
    end
  end

endmodule

`default_nettype wire

### tb/sv/four_level_page_table_walker_core_tb.sv
// self-checking testbench for four_level_page_table_walker_core: page tables built in memory,
// random walks and writes under varied handshake pressure, scoreboard holds the walk predictor
// depends on ptw_pkg and the four_level_page_table_walker_core rtl
`default_nettype none

module four_level_page_table_walker_core_tb
  import ptw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int SHOWN_ERRORS   = 10;
  localparam int RECENT_DEPTH   = 32;

  // ways a table chain can be spoiled on purpose
  typedef enum int {
    WALK_CLEAN,
    WALK_ABSENT,
    WALK_FAR,
    WALK_SKIPPED
  } walk_flaw_t;

  typedef struct packed {
    logic        mapped;
    logic [63:0] phys;
  } walk_result_t;

  // memory shadow, root copy and the queue of translations still owed by the block
  class walk_scoreboard;
    bit [63:0]    mem [MEM_WORDS];
    bit [63:0]    root;
    walk_result_t due_translations[$];
    int           errors;
    int           writes;
    int           translates;
    int           hits;
    int           misses;

    function void set_root(bit [63:0] value);
      root = value;
    endfunction

    // walk the shadow tables the way the block should
    function walk_result_t walk_tables(bit [63:0] laddr);
      walk_result_t res;
      bit [63:0]    base;
      bit [63:0]    entry;
      bit [63:0]    byte_addr;
      bit [8:0]     idx;
      res.mapped = 1'b1;
      res.phys   = '0;
      base = root & ~PAGE_MASK;
      for (int lvl = LEVELS; lvl > 0; lvl--) begin
        idx       = 9'(laddr >> (PAGE_SHIFT + IDX_BITS * (lvl - 1)));
        byte_addr = base + {52'd0, idx, 3'b000};
        // entries past the end of memory read as zero
        if ((byte_addr >> 3) < MEM_WORDS) begin
          entry = mem[byte_addr[ADDR_W+2:3]];
        end else begin
          entry = '0;
        end
        if (!entry[0]) begin
          res.mapped = 1'b0;
          break;
        end
        base = entry & ~PAGE_MASK;
      end
      if (res.mapped) begin
        res.phys = base | (laddr & PAGE_MASK);
      end
      return res;
    endfunction

    function void note_request(bit kind, bit [11:0] widx, bit [63:0] wdata,
                               bit [63:0] laddr);
      walk_result_t res;
      if (kind == REQ_WRITE) begin
        if (widx < MEM_WORDS) begin
          mem[widx] = wdata;
        end
        writes++;
      end else begin
        res = walk_tables(laddr);
        due_translations.push_back(res);
        translates++;
        if (res.mapped) begin
          hits++;
        end else begin
          misses++;
        end
      end
    endfunction

    function void flag(string what, bit [63:0] want, bit [63:0] got);
      errors++;
      if (errors <= SHOWN_ERRORS) begin
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(bit got_mapped, bit [63:0] got_phys);
      walk_result_t want;
      if (due_translations.size() == 0) begin
        flag("result word with no translation pending, physical_addr", '0, got_phys);
        return;
      end
      want = due_translations.pop_front();
      if (got_mapped !== want.mapped) begin
        flag("mapped", {63'd0, want.mapped}, {63'd0, got_mapped});
      end
      if (got_phys !== want.phys) begin
        flag("physical_addr", want.phys, got_phys);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] page_table_root = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_WRITE;
  logic [11:0] word_index = '0;
  logic [63:0] write_data = '0;
  logic [63:0] linear_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        mapped;
  logic [63:0] physical_addr;

  walk_scoreboard sb;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          roots_set = 0;
  int          quiet_cycles = 0;
  logic [63:0] recent_walks[$];

  four_level_page_table_walker_core DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .page_table_root (page_table_root),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .word_index      (word_index),
    .write_data      (write_data),
    .linear_addr     (linear_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mapped          (mapped),
    .physical_addr   (physical_addr)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // observe every handshake and feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_root(page_table_root);
      end
      if (in_valid && !in_stall) begin
        sb.note_request(req_type, word_index, write_data, linear_addr);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(mapped, physical_addr);
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d translations outstanding",
               sb.due_translations.size());
      $display("four_level_page_table_walker_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [8:0] level_index(logic [63:0] laddr, int lvl);
    return 9'(laddr >> (PAGE_SHIFT + IDX_BITS * (lvl - 1)));
  endfunction

  // present pointer to one of the eight tables that fit in memory
  function automatic logic [63:0] table_ptr(logic [2:0] tab);
    return {49'd0, tab, 11'($urandom), 1'b1};
  endfunction

  // one request word, with random idle cycles ahead of it
  task automatic push_request(input logic kind, input logic [11:0] widx,
                              input logic [63:0] wdata, input logic [63:0] laddr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    word_index  <= widx;
    write_data  <= wdata;
    linear_addr <= laddr;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic store_word(input logic [11:0] widx, input logic [63:0] wdata);
    push_request(REQ_WRITE, widx, wdata, rand64());
  endtask

  task automatic translate(input logic [63:0] laddr);
    push_request(REQ_TRANSLATE, 12'($urandom), rand64(), laddr);
  endtask

  // lay down the four entries that map laddr, optionally spoiling one level
  task automatic map_walk(input logic [2:0] top_tab, input logic [63:0] laddr,
                          input logic [63:0] leaf, input walk_flaw_t flaw,
                          input int flaw_lvl);
    logic [2:0]  tab [1:4];
    logic [63:0] entry;
    tab[4] = top_tab;
    for (int i = 1; i < 4; i++) begin
      tab[i] = 3'($urandom);
    end
    for (int lvl = 4; lvl > 0; lvl--) begin
      entry = (lvl == 1) ? leaf : table_ptr(tab[lvl-1]);
      if (lvl == flaw_lvl) begin
        case (flaw)
          WALK_ABSENT: begin
            entry[0] = 1'b0;
          end
          WALK_FAR: begin
            entry[15 + $urandom_range(48)] = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (!(flaw == WALK_SKIPPED && lvl == flaw_lvl)) begin
        store_word({tab[lvl], level_index(laddr, lvl)}, entry);
      end
    end
  endtask

  // stop sending and wait for every owed result plus the block's tail latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_translations.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_root(input logic [63:0] value);
    cfg_valid       <= 1'b1;
    page_table_root <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    roots_set++;
  endtask

  // one root setting under one idling mix, mostly well-formed table chains
  task automatic run_phase(input logic [63:0] root, input int send_pct,
                           input int recv_pct, input int count);
    int          target;
    int          pause_at;
    int          pick;
    bit          paused;
    logic [63:0] la;
    settle();
    program_root(root);
    sender_idle_pct = send_pct;
    stall_pct       = recv_pct;
    target          = items_sent + count;
    pause_at        = items_sent + count / 2;
    paused          = 1'b0;
    while (items_sent < target) begin
      if (!paused && items_sent >= pause_at) begin
        settle();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      la   = rand64();
      if (pick < 55) begin
        map_walk(root[14:12], la, rand64() | 64'h1, WALK_CLEAN, 1);
        translate(la);
        if (recent_walks.size() == RECENT_DEPTH) begin
          void'(recent_walks.pop_front());
        end
        recent_walks.push_back(la);
      end else if (pick < 70) begin
        map_walk(root[14:12], la, rand64() | 64'h1,
                 walk_flaw_t'($urandom_range(3, 1)), $urandom_range(4, 1));
        translate(la);
      end else if (pick < 80 && recent_walks.size() > 0) begin
        // revisit an earlier mapping with new offset and ignored upper bits
        la = recent_walks[$urandom_range(recent_walks.size() - 1)];
        la[63:48] = 16'($urandom);
        la[11:0]  = 12'($urandom);
        translate(la);
      end else if (pick < 90) begin
        translate(la);
      end else begin
        store_word(12'($urandom), rand64());
      end
    end
  endtask

  initial begin
    sb = new;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tables, edge indices, ignored bits, absent and far entries
    program_root(64'h0000_0000_0000_1abc);
    translate(64'h0);
    store_word(12'hfff, 64'hFFFF_FFFF_FFFF_FFFF);
    store_word(12'h000, 64'h0);
    map_walk(3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_F001, WALK_CLEAN, 1);
    translate(64'hFFFF_FFFF_FFFF_FFFF);
    translate(64'h0000_FFFF_FFFF_F123);
    map_walk(3'd1, 64'h0, 64'h0000_0000_0000_0001, WALK_CLEAN, 1);
    translate(64'h0);
    translate(64'h0000_0000_0000_1000);
    map_walk(3'd1, 64'h0000_8040_2010_0555, rand64() | 64'h1, WALK_ABSENT, 2);
    translate(64'h0000_8040_2010_0555);
    map_walk(3'd1, 64'h0000_4020_1008_0aaa, rand64() | 64'h1, WALK_FAR, 3);
    translate(64'h0000_4020_1008_0aaa);

    // random phases across root settings and idling mixes
    run_phase(64'h0, 0, 0, 160);
    run_phase(64'h0000_0000_0000_7fff, 70, 0, 160);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 0, 70, 60);
    run_phase({49'd0, 15'($urandom)}, 19, 19, 180);
    run_phase(rand64(), 0, 0, 40);
    run_phase({49'd0, 15'($urandom)}, 0, 70, 200);
    run_phase(64'h0000_0000_0000_3000, 19, 19, 150);

    settle();
    if (sb.due_translations.size() != 0) begin
      $display("%0d translations never returned", sb.due_translations.size());
    end
    $display("covered %0d word writes and %0d translations (%0d mapped, %0d unmapped)",
             sb.writes, sb.translates, sb.hits, sb.misses);
    $display("across %0d root settings, %0d mismatches", roots_set, sb.errors);
    if (sb.errors == 0 && sb.due_translations.size() == 0) begin
      $display("four_level_page_table_walker_core regression: pass");
    end else begin
      $display("four_level_page_table_walker_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
